[hw/rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the hash table checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset
`define LPHT_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be seen at a clock edge outside reset
`define LPHT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[hw/rtl/lpht_pkg.sv]
// ---------------------------------------------------------------------------
// lpht_pkg
// Types, sizes, status codes and hash constants of the hash table.
// ---------------------------------------------------------------------------
package lpht_pkg;

  // Table geometry (power of two: the home slot is the low bits of the sum)
  localparam int TABLE_SIZE = 1024;
  localparam int IDX_W      = $clog2(TABLE_SIZE);
  localparam int CNT_W      = $clog2(TABLE_SIZE + 1);

  // Field widths
  localparam int KEY_W       = 54;
  localparam int DATA_W      = 32;
  localparam int HASH_W      = 32;
  localparam int STATUS_W    = 3;
  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 56;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EXISTS    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;

  // Action codes carried in tuser
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  // Hash mixing constants
  localparam logic [HASH_W-1:0] HASH_XOR     = 32'h0000_0010;
  localparam logic [HASH_W-1:0] HASH_MUL     = 32'd33;
  localparam logic [HASH_W-1:0] HASH_SUB_XOR = 32'd3;
  localparam int                HASH_SHIFT   = 5;

  // One table entry as held in memory
  typedef struct packed {
    logic              valid;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] data;
  } entry_t;

  // Memory access request
  typedef struct packed {
    logic             we;
    logic             re;
    logic [IDX_W-1:0] addr;
  } mem_cmd_t;

  // Result item, status in the lowest bits
  typedef struct packed {
    logic [CNT_W-1:0]    entry_count;
    logic [DATA_W-1:0]   found_data;
    logic [IDX_W-1:0]    slot;
    logic [STATUS_W-1:0] status;
  } result_t;

endpackage

[hw/rtl/lpht_hash.sv]
// ---------------------------------------------------------------------------
// lpht_hash
// Multi-cycle home slot hash around one shared 32x32 multiplier, plus a multiply by HASH_MUL in the mix step.
// ---------------------------------------------------------------------------
module lpht_hash (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [lpht_pkg::HASH_W-1:0] key_lo,
  output logic                       done,
  output logic [lpht_pkg::IDX_W-1:0]  home
);
  import lpht_pkg::*;

  // Step codes
  localparam logic [2:0] HS_KK  = 3'd0;
  localparam logic [2:0] HS_MIX = 3'd1;
  localparam logic [2:0] HS_SUB = 3'd2;
  localparam logic [2:0] HS_KEY = 3'd3;
  localparam logic [2:0] HS_TOP = 3'd4;
  localparam logic [2:0] HS_IDX = 3'd5;

  logic              busy_r;
  logic [2:0]        step_r;
  logic              done_r;
  logic [HASH_W-1:0] k_r;
  logic [HASH_W-1:0] kk_r;
  logic [HASH_W-1:0] h_r;
  logic [HASH_W-1:0] top_r;
  logic [IDX_W-1:0]  home_r;
  logic [HASH_W-1:0] mul_a;
  logic [HASH_W-1:0] mul_b;
  logic [HASH_W-1:0] prod;

  // Select multiplier operands for the current step
  always_comb begin
    mul_a = k_r;
    mul_b = k_r;
    case (step_r)
      HS_SUB: begin
        mul_a = h_r;
        mul_b = (k_r ^ HASH_SUB_XOR) - h_r;
      end
      HS_KEY: begin
        mul_a = h_r;
        mul_b = k_r;
      end
      HS_TOP: begin
        mul_a = h_r;
        mul_b = h_r << HASH_SHIFT;
      end
      default: begin
        mul_a = k_r;
        mul_b = k_r;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // Sequence control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= HS_KK;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= HS_KK;
      end else if (busy_r) begin
        if (step_r == HS_IDX) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          step_r <= step_r + 3'd1;
        end
      end
    end
  end

  // Datapath: each step's result is registered before the next step
  always_ff @(posedge clk) begin
    if (start) begin
      k_r <= key_lo;
    end else if (busy_r) begin
      case (step_r)
        HS_KK:  kk_r  <= prod;
        HS_MIX: h_r   <= ((k_r + kk_r) ^ HASH_XOR) + k_r * HASH_MUL;
        HS_SUB: h_r   <= prod;
        HS_KEY: h_r   <= prod;
        HS_TOP: top_r <= prod;
        // Low bits of the 64-bit sum; k*k low bits match the 32-bit square
        HS_IDX: home_r <= top_r[IDX_W-1:0] + kk_r[IDX_W-1:0] + h_r[IDX_W-1:0];
        default: ;
      endcase
    end
  end

  assign done = done_r;
  assign home = home_r;

endmodule

[hw/rtl/lpht_table.sv]
// ---------------------------------------------------------------------------
// lpht_table
// Entry memory: one write and one registered read per cycle.
// ---------------------------------------------------------------------------
module lpht_table (
  input  logic                clk,
  input  lpht_pkg::mem_cmd_t  cmd,
  input  lpht_pkg::entry_t    wdata,
  output lpht_pkg::entry_t    rdata
);
  import lpht_pkg::*;

  entry_t mem [TABLE_SIZE];
  entry_t rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (cmd.we) begin
      mem[cmd.addr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (cmd.re) begin
      rdata_r <= mem[cmd.addr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/linear_probe_hash_table.sv]
// Flow: an item passes S_IDLE, S_HASH, S_READ and S_CHECK to S_DONE and the output
//   register; each further probe repeats S_READ and S_CHECK (one memory read each).
// Items: one item at a time; full-table insert and empty-table lookup go
//   straight from S_IDLE to S_DONE without hashing.
// Reset: a clearing pass writes all 1024 entries invalid; no input is taken
//   until it ends.
// ---------------------------------------------------------------------------
// linear_probe_hash_table
// Open-addressing key/data table with linear probing over one entry memory.
// ---------------------------------------------------------------------------
module linear_probe_hash_table (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [lpht_pkg::IN_TDATA_W-1:0]   in_tdata,   // key[53:0], entry_data[85:54]
  input  logic                              in_tuser,   // action[0]
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [lpht_pkg::OUT_TDATA_W-1:0]  out_tdata   // status, slot, found_data, entry_count
);
  import lpht_pkg::*;

  // Controller states
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_HASH  = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_CHECK = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]        state_r,    state_nxt;
  logic [IDX_W-1:0]  clr_addr_r, clr_addr_nxt;
  logic [CNT_W-1:0]  count_r,    count_nxt;
  logic              out_vld_r,  out_vld_nxt;
  result_t           out_res_r,  out_res_nxt;
  result_t           res_r,      res_nxt;
  logic              act_r,      act_nxt;
  logic [KEY_W-1:0]  key_r,      key_nxt;
  logic [DATA_W-1:0] data_r,     data_nxt;
  logic [IDX_W-1:0]  idx_r,      idx_nxt;
  logic [IDX_W-1:0]  probes_r,   probes_nxt;

  logic              in_xfer;
  logic              hash_start;
  logic              hash_done;
  logic [IDX_W-1:0]  home;
  mem_cmd_t          cmd;
  entry_t            wdata;
  entry_t            rdata;
  logic [KEY_W-1:0]  in_key;
  logic [DATA_W-1:0] in_data;

  assign in_key   = in_tdata[KEY_W-1:0];
  assign in_data  = in_tdata[KEY_W +: DATA_W];
  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;

  lpht_hash u_hash (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (hash_start),
    .key_lo (in_key[HASH_W-1:0]),
    .done   (hash_done),
    .home   (home)
  );

  lpht_table u_table (
    .clk   (clk),
    .cmd   (cmd),
    .wdata (wdata),
    .rdata (rdata)
  );

  // Next-state and datapath control
  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    count_nxt    = count_r;
    out_vld_nxt  = out_vld_r;
    out_res_nxt  = out_res_r;
    res_nxt      = res_r;
    act_nxt      = act_r;
    key_nxt      = key_r;
    data_nxt     = data_r;
    idx_nxt      = idx_r;
    probes_nxt   = probes_r;
    hash_start   = 1'b0;
    cmd          = '0;
    wdata        = '0;

    // Drop the output once transferred
    if (out_vld_r && out_tready) begin
      out_vld_nxt = 1'b0;
    end

    unique case (state_r)
      // Sweep the memory, writing every entry invalid
      S_CLEAR: begin
        cmd.we       = 1'b1;
        cmd.addr     = clr_addr_r;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == IDX_W'(TABLE_SIZE - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      // Take an item; settle full and empty cases at once
      S_IDLE: begin
        if (in_xfer) begin
          act_nxt  = in_tuser;
          key_nxt  = in_key;
          data_nxt = in_data;
          res_nxt  = '0;
          res_nxt.entry_count = count_r;
          if (in_tuser == ACT_INSERT && count_r >= CNT_W'(TABLE_SIZE)) begin
            res_nxt.status = ST_FULL;
            state_nxt      = S_DONE;
          end else if (in_tuser == ACT_LOOKUP && count_r == '0) begin
            res_nxt.status = ST_EMPTY;
            state_nxt      = S_DONE;
          end else begin
            hash_start = 1'b1;
            state_nxt  = S_HASH;
          end
        end
      end

      // Wait for the home slot
      S_HASH: begin
        if (hash_done) begin
          idx_nxt    = home;
          probes_nxt = '0;
          state_nxt  = S_READ;
        end
      end

      // Issue the probe read
      S_READ: begin
        cmd.re    = 1'b1;
        cmd.addr  = idx_r;
        state_nxt = S_CHECK;
      end

      // Examine the probed entry
      S_CHECK: begin
        state_nxt = S_DONE;
        if (!rdata.valid) begin
          if (act_r == ACT_INSERT) begin
            cmd.we      = 1'b1;
            cmd.addr    = idx_r;
            wdata.valid = 1'b1;
            wdata.key   = key_r;
            wdata.data  = data_r;
            count_nxt   = count_r + 1'b1;
            res_nxt.status      = ST_OK;
            res_nxt.slot        = idx_r;
            res_nxt.entry_count = count_r + 1'b1;
          end else begin
            res_nxt.status = ST_NOT_FOUND;
          end
        end else if (rdata.key == key_r) begin
          res_nxt.slot = idx_r;
          if (act_r == ACT_INSERT) begin
            res_nxt.status = ST_EXISTS;
          end else begin
            res_nxt.status     = ST_OK;
            res_nxt.found_data = rdata.data;
          end
        end else if (probes_r == {IDX_W{1'b1}}) begin
          // Whole table walked
          res_nxt.status = (act_r == ACT_INSERT) ? ST_FULL : ST_NOT_FOUND;
        end else begin
          // Advance to the next slot, wrapping at the end
          idx_nxt    = idx_r + 1'b1;
          probes_nxt = probes_r + 1'b1;
          state_nxt  = S_READ;
        end
      end

      // Hold the result until the output register is free
      S_DONE: begin
        if (!out_vld_r || out_tready) begin
          out_vld_nxt = 1'b1;
          out_res_nxt = res_r;
          state_nxt   = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      clr_addr_r <= '0;
      count_r    <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      count_r    <= count_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
    res_r     <= res_nxt;
    act_r     <= act_nxt;
    key_r     <= key_nxt;
    data_r    <= data_nxt;
    idx_r     <= idx_nxt;
    probes_r  <= probes_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_res_r;

endmodule

[hw/rtl/lpht_checker.sv]
// ---------------------------------------------------------------------------
// lpht_checker
// Port-level checks of the hash table, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module lpht_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [lpht_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import lpht_pkg::*;

  // Stalled result holds
  `LPHT_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "result changed while stalled")

  // One item at a time: ready drops after each input transfer
  `LPHT_ASSERT(a_one_item, clk, rst_n, in_tvalid && in_tready |=> !in_tready, "second item taken while busy")

  // Data word only on a successful result
  `LPHT_NEVER(a_data_zero, clk, rst_n, out_tvalid && out_tdata[2:0] != ST_OK && out_tdata[44:13] != '0, "data on failed result")

  // Slot is zero for full, empty and not-found results
  `LPHT_NEVER(a_slot_zero, clk, rst_n, out_tvalid && (out_tdata[2:0] == ST_FULL || out_tdata[2:0] == ST_EMPTY || out_tdata[2:0] == ST_NOT_FOUND) && out_tdata[12:3] != '0, "slot on miss")

  // Entry count bounded by table size
  `LPHT_NEVER(a_count_max, clk, rst_n, out_tvalid && out_tdata[55:45] > CNT_W'(TABLE_SIZE), "entry count overflow")

endmodule

bind linear_probe_hash_table lpht_checker u_lpht_checker (.*);
